// ----- sv/ntus_pkg.sv -----
// shared types and constants of the neighbor table with uplink select
// no dependencies
`default_nettype none

package ntus_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int HEADER_BYTES  = 9;
    localparam int MAX_RESULTS   = 64;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SCAN_W = $clog2(TABLE_ENTRIES + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_NODE_ID      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_TEAM         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_MAGIC   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_VERSION = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEAM_LEAD_CODE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPLINK_AGE_MS    = 3'd5;

    localparam logic [15:0] OWN_NODE_ID_RESET      = 16'd1;
    localparam logic [7:0]  OWN_TEAM_RESET         = 8'd0;
    localparam logic [15:0] EXPECTED_MAGIC_RESET   = 16'd0;
    localparam logic [7:0]  EXPECTED_VERSION_RESET = 8'd1;
    localparam logic [1:0]  TEAM_LEAD_CODE_RESET   = 2'd1;
    localparam logic [31:0] UPLINK_AGE_MS_RESET    = 32'd15000;

    localparam logic [1:0] ACT_HEADER = 2'd0;
    localparam logic [1:0] ACT_UPLINK = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    localparam logic [3:0] ST_STORED = 4'd0;
    localparam logic [3:0] ST_SHORT  = 4'd1;
    localparam logic [3:0] ST_BADHDR = 4'd2;
    localparam logic [3:0] ST_ECHO   = 4'd3;
    localparam logic [3:0] ST_UPLINK = 4'd4;
    localparam logic [3:0] ST_NONE   = 4'd5;
    localparam logic [3:0] ST_ENTRY  = 4'd6;
    localparam logic [3:0] ST_EMPTY  = 4'd7;
    localparam logic [3:0] ST_FULL   = 4'd8;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_ms;
        logic [15:0]        src_node_id;
        logic [47:0]        src_mac;
        logic [7:0]         frame_len;
        logic [15:0]        frame_magic;
        logic [7:0]         frame_version;
        logic [1:0]         src_role;
        logic [7:0]         src_team;
        logic signed [7:0]  rx_rssi;
        logic [1:0]         wanted_role;
        logic [31:0]        age_limit_ms;
    } item_t;

    typedef struct packed {
        logic [3:0]         status;
        logic [15:0]        node_id;
        logic signed [7:0]  rssi;
        logic [31:0]        heard_ms;
        logic [47:0]        node_mac;
        logic [1:0]         node_role;
        logic [7:0]         node_team;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] value;
    } cfg_word_t;

    typedef struct packed {
        logic [15:0]        node;
        logic [47:0]        mac;
        logic signed [7:0]  rssi;
        logic [31:0]        seen;
        logic [1:0]         role;
        logic [7:0]         team;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic result_t entry_result(logic [3:0] st, entry_t e, logic last);
        result_t r;
        r.status       = st;
        r.node_id      = e.node;
        r.rssi         = e.rssi;
        r.heard_ms     = e.seen;
        r.node_mac     = e.mac;
        r.node_role    = e.role;
        r.node_team    = e.team;
        r.last         = last;
        return r;
    endfunction

    function automatic result_t empty_result(logic [3:0] st, logic [15:0] node);
        result_t r;
        r         = '0;
        r.status  = st;
        r.node_id = node;
        r.last    = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ntus_if.sv -----
// valid/ready channel interfaces for items, results and config writes
// depends on ntus_pkg
`default_nettype none

interface ntus_item_if;
    logic               valid;
    logic               ready;
    ntus_pkg::item_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ntus_result_if;
    logic               valid;
    logic               ready;
    ntus_pkg::result_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ntus_cfg_if;
    logic                valid;
    logic                ready;
    ntus_pkg::cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/ntus_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ntus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/neighbor_table_uplink_select.sv -----
// top level of the neighbor table: header check, insert/update, uplink and fresh-list scans
// depends on ntus_pkg, ntus_if and ntus_ram
`default_nettype none

// The neighbor table lives in one ram of TABLE_ENTRIES entries with registered
// read data; occupancy is kept in flip-flops that reset clears at once, so the block
// is ready right after reset with no clearing pass. Every accepted item that
// needs the table makes at least one scan, one entry per cycle through the ram read port.
// A header that fails the length, magic/version or own-echo check is answered
// without a scan. A header that is stored or rejected as table-full, and an
// uplink query, take one full scan of the table. A fresh-list query makes one
// scan per reported entry plus a final one unless MAX_RESULTS is reached, and
// reports at most MAX_RESULTS results. Action code 3 is taken and dropped.
// Config writes are taken in any cycle and must only come while the block is
// idle. Results sit in an output register, so the sink may stall.

module neighbor_table_uplink_select (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ntus_item_if.sink     item,
    ntus_result_if.source result,
    ntus_cfg_if.sink      cfg
);

    import ntus_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_LASTPEND,
        S_EMIT
    } state_t;

    state_t              state_reg;
    state_t              ret_reg;
    item_t               cmd_reg;

    logic [15:0]         own_node_id_reg;
    logic [7:0]          own_team_reg;
    logic [15:0]         expected_magic_reg;
    logic [7:0]          expected_version_reg;
    logic [1:0]          team_lead_code_reg;
    logic [31:0]         uplink_age_ms_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [SCAN_W-1:0]   issue_reg;
    logic                rd_v_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                found_reg;
    entry_t              best_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic                prev_vld_reg;
    logic [15:0]         prev_node_reg;
    logic                pend_vld_reg;
    entry_t              pend_reg;
    logic [RES_W-1:0]    count_reg;

    result_t             word_reg;
    result_t             out_reg;
    logic                out_v_reg;

    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;
    logic                rd_valid_bit;
    logic [31:0]         age;
    logic                cand;
    logic                take;
    logic                scan_done;
    logic                out_free;
    logic                accept;
    logic                hdr_short;
    logic                hdr_bad;
    logic                hdr_echo;
    entry_t              new_entry;
    logic                ram_we;
    logic [IDX_W-1:0]    slot;
    logic [RES_W-1:0]    count_next;
    logic                hit_max;

    ntus_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (new_entry),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign item.ready   = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = out_v_reg;
    assign result.data  = out_reg;

    assign accept   = item.valid && (state_reg == S_IDLE);
    assign out_free = !out_v_reg || result.ready;

    assign hdr_short = item.data.frame_len < 8'(HEADER_BYTES);
    assign hdr_bad   = (item.data.frame_magic != expected_magic_reg)
                    || (item.data.frame_version != expected_version_reg);
    assign hdr_echo  = item.data.src_node_id == own_node_id_reg;

    assign rd_entry     = entry_t'(ram_rdata);
    assign rd_valid_bit = valid_reg[rd_idx_reg];
    assign age          = cmd_reg.now_ms - rd_entry.seen;

    always_comb
    begin
        case (cmd_reg.action)
            ACT_HEADER:
                cand = rd_valid_bit && (rd_entry.node == cmd_reg.src_node_id);
            ACT_UPLINK:
                cand = rd_valid_bit && (rd_entry.role == cmd_reg.wanted_role)
                    && ((cmd_reg.wanted_role != team_lead_code_reg)
                        || (rd_entry.team == own_team_reg))
                    && (age <= uplink_age_ms_reg);
            ACT_LIST:
                cand = rd_valid_bit
                    && (!prev_vld_reg || (rd_entry.node > prev_node_reg))
                    && (age <= cmd_reg.age_limit_ms);
            default:
                cand = 1'b0;
        endcase
    end

    assign take      = rd_v_reg && cand && (!found_reg || (rd_entry.node < best_reg.node));
    assign scan_done = rd_v_reg && (rd_idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_comb
    begin
        new_entry.node = cmd_reg.src_node_id;
        new_entry.mac  = cmd_reg.src_mac;
        new_entry.rssi = cmd_reg.rx_rssi;
        new_entry.seen = cmd_reg.now_ms;
        new_entry.role = cmd_reg.src_role;
        new_entry.team = cmd_reg.src_team;
    end

    assign slot   = found_reg ? best_idx_reg : free_idx_reg;
    assign ram_we = (state_reg == S_FINISH) && (cmd_reg.action == ACT_HEADER)
                 && (found_reg || free_found_reg);

    assign count_next = count_reg + RES_W'(1);
    assign hit_max    = count_next == RES_W'(MAX_RESULTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            ret_reg              <= S_IDLE;
            cmd_reg              <= '0;
            own_node_id_reg      <= OWN_NODE_ID_RESET;
            own_team_reg         <= OWN_TEAM_RESET;
            expected_magic_reg   <= EXPECTED_MAGIC_RESET;
            expected_version_reg <= EXPECTED_VERSION_RESET;
            team_lead_code_reg   <= TEAM_LEAD_CODE_RESET;
            uplink_age_ms_reg    <= UPLINK_AGE_MS_RESET;
            valid_reg            <= '0;
            issue_reg            <= '0;
            rd_v_reg             <= 1'b0;
            rd_idx_reg           <= '0;
            found_reg            <= 1'b0;
            best_reg             <= '0;
            best_idx_reg         <= '0;
            free_found_reg       <= 1'b0;
            free_idx_reg         <= '0;
            prev_vld_reg         <= 1'b0;
            prev_node_reg        <= '0;
            pend_vld_reg         <= 1'b0;
            pend_reg             <= '0;
            count_reg            <= '0;
            word_reg             <= '0;
            out_reg              <= '0;
            out_v_reg            <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.data.addr)
                    CFG_OWN_NODE_ID:      own_node_id_reg      <= cfg.data.value[15:0];
                    CFG_OWN_TEAM:         own_team_reg         <= cfg.data.value[7:0];
                    CFG_EXPECTED_MAGIC:   expected_magic_reg   <= cfg.data.value[15:0];
                    CFG_EXPECTED_VERSION: expected_version_reg <= cfg.data.value[7:0];
                    CFG_TEAM_LEAD_CODE:   team_lead_code_reg   <= cfg.data.value[1:0];
                    CFG_UPLINK_AGE_MS:    uplink_age_ms_reg    <= cfg.data.value[31:0];
                    default:              ;
                endcase
            end

            if ((state_reg == S_EMIT) && out_free)
            begin
                out_v_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_v_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg        <= item.data;
                        issue_reg      <= '0;
                        rd_v_reg       <= 1'b0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        prev_vld_reg   <= 1'b0;
                        pend_vld_reg   <= 1'b0;
                        count_reg      <= '0;
                        ret_reg        <= S_IDLE;
                        case (item.data.action)
                            ACT_HEADER:
                            begin
                                if (hdr_short)
                                begin
                                    word_reg  <= empty_result(ST_SHORT, 16'd0);
                                    state_reg <= S_EMIT;
                                end
                                else if (hdr_bad)
                                begin
                                    word_reg  <= empty_result(ST_BADHDR, 16'd0);
                                    state_reg <= S_EMIT;
                                end
                                else if (hdr_echo)
                                begin
                                    word_reg  <= empty_result(ST_ECHO, 16'd0);
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            ACT_UPLINK,
                            ACT_LIST:
                                state_reg <= S_SCAN;
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (issue_reg < SCAN_W'(TABLE_ENTRIES))
                    begin
                        issue_reg  <= issue_reg + SCAN_W'(1);
                        rd_v_reg   <= 1'b1;
                        rd_idx_reg <= issue_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        rd_v_reg <= 1'b0;
                    end
                    if (rd_v_reg && !rd_valid_bit && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= rd_idx_reg;
                    end
                    if (take)
                    begin
                        found_reg    <= 1'b1;
                        best_reg     <= rd_entry;
                        best_idx_reg <= rd_idx_reg;
                    end
                    if (scan_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    case (cmd_reg.action)
                        ACT_HEADER:
                        begin
                            if (found_reg || free_found_reg)
                            begin
                                valid_reg[slot] <= 1'b1;
                                word_reg        <= entry_result(ST_STORED, new_entry, 1'b1);
                            end
                            else
                            begin
                                word_reg <= empty_result(ST_FULL, cmd_reg.src_node_id);
                            end
                            state_reg <= S_EMIT;
                        end
                        ACT_UPLINK:
                        begin
                            if (found_reg)
                            begin
                                word_reg <= entry_result(ST_UPLINK, best_reg, 1'b1);
                            end
                            else
                            begin
                                word_reg <= empty_result(ST_NONE, 16'd0);
                            end
                            state_reg <= S_EMIT;
                        end
                        ACT_LIST:
                        begin
                            if (found_reg)
                            begin
                                // hold the new entry until the next pass tells whether it is last
                                count_reg      <= count_next;
                                pend_reg       <= best_reg;
                                pend_vld_reg   <= 1'b1;
                                prev_vld_reg   <= 1'b1;
                                prev_node_reg  <= best_reg.node;
                                issue_reg      <= '0;
                                rd_v_reg       <= 1'b0;
                                found_reg      <= 1'b0;
                                free_found_reg <= 1'b0;
                                if (pend_vld_reg)
                                begin
                                    word_reg  <= entry_result(ST_ENTRY, pend_reg, 1'b0);
                                    ret_reg   <= hit_max ? S_LASTPEND : S_SCAN;
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= hit_max ? S_LASTPEND : S_SCAN;
                                end
                            end
                            else
                            begin
                                if (pend_vld_reg)
                                begin
                                    word_reg <= entry_result(ST_ENTRY, pend_reg, 1'b1);
                                end
                                else
                                begin
                                    word_reg <= empty_result(ST_EMPTY, 16'd0);
                                end
                                ret_reg   <= S_IDLE;
                                state_reg <= S_EMIT;
                            end
                        end
                        default:
                            state_reg <= S_IDLE;
                    endcase
                end

                S_LASTPEND:
                begin
                    word_reg  <= entry_result(ST_ENTRY, pend_reg, 1'b1);
                    ret_reg   <= S_IDLE;
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= word_reg;
                        state_reg <= ret_reg;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
